// ----- design/text_console_cursor_controller_macros.svh -----
// Assertion macros for the text console cursor controller.
`ifndef TEXT_CONSOLE_CURSOR_CONTROLLER_MACROS_SVH
`define TEXT_CONSOLE_CURSOR_CONTROLLER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define TCC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define TCC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/tcc_pkg.sv -----
// Shared types and codes of the text console cursor controller.
package tcc_pkg;

	localparam logic [7:0] WIDE_FIRST = 8'hA1;
	localparam logic [7:0] CH_BS      = 8'h08;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_NL      = 8'h0A;
	localparam logic [7:0] CH_CR      = 8'h0D;
	localparam logic [7:0] CH_SPACE   = 8'h20;

	localparam logic [1:0] KIND_NARROW = 2'd0;
	localparam logic [1:0] KIND_WIDE   = 2'd1;
	localparam logic [1:0] KIND_SCROLL = 2'd2;

	localparam logic [1:0] REG_COLUMNS = 2'd0;
	localparam logic [1:0] REG_ROWS    = 2'd1;
	localparam logic [1:0] REG_FORE    = 2'd2;
	localparam logic [1:0] REG_BACK    = 2'd3;

	// cursor moves
	localparam logic [2:0] MV_NONE   = 3'd0;
	localparam logic [2:0] MV_ADV1   = 3'd1;
	localparam logic [2:0] MV_ADV2   = 3'd2;
	localparam logic [2:0] MV_BACK   = 3'd3;
	localparam logic [2:0] MV_NL     = 3'd4;
	localparam logic [2:0] MV_CR     = 3'd5;
	localparam logic [2:0] MV_SCROLL = 3'd6;

	// what the output register is loaded with
	localparam logic [1:0] DOP_CHAR   = 2'd0;
	localparam logic [1:0] DOP_SPACE  = 2'd1;
	localparam logic [1:0] DOP_WIDE   = 2'd2;
	localparam logic [1:0] DOP_SCROLL = 2'd3;

	typedef struct packed {
		logic       load;
		logic       set_lead;
		logic       clr_lead;
		logic [2:0] mv;
		logic       emit;
		logic [1:0] dop;
		logic       last;
	} tcc_cmd_t;

	typedef struct packed {
		logic is_wide;
		logic is_bs;
		logic is_nl;
		logic is_cr;
		logic is_tab;
		logic lead_pend;
		logic last_col;
		logic origin;
		logic over;
		logic adv1_over;
		logic adv2_over;
		logic out_free;
	} tcc_stat_t;

endpackage

// ----- design/tcc_datapath.sv -----
// Cursor, lead byte, geometry and color registers plus the result register.
module tcc_datapath #(
	parameter int MAX_COLS = 128,
	parameter int MAX_ROWS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        in_byte,
	input  tcc_pkg::tcc_cmd_t cmd,
	input  logic              cfg_wr,
	input  logic [1:0]        cfg_index,
	input  logic [23:0]       cfg_data,
	input  logic              out_ready,
	output tcc_pkg::tcc_stat_t stat,
	output logic              out_valid,
	output logic [1:0]        out_kind,
	output logic [5:0]        out_row,
	output logic [6:0]        out_col,
	output logic [7:0]        out_code1,
	output logic [7:0]        out_code2,
	output logic [23:0]       out_color,
	output logic              out_last
);
	import tcc_pkg::*;

	localparam int COL_W = (MAX_COLS > 2) ? $clog2(MAX_COLS) : 1;
	localparam int ROW_W = $clog2(MAX_ROWS + 1);

	function automatic logic [COL_W-1:0] clamp_cols(input logic [7:0] v);
		logic [8:0] e;
		e = {1'b0, v};
		if (e < 9'd2) e = 9'd2;
		if (e > 9'(MAX_COLS)) e = 9'(MAX_COLS);
		return COL_W'(e - 9'd1);
	endfunction

	function automatic logic [ROW_W-1:0] clamp_rows(input logic [6:0] v);
		logic [8:0] e;
		e = {2'b00, v};
		if (e < 9'd1) e = 9'd1;
		if (e > 9'(MAX_ROWS)) e = 9'(MAX_ROWS);
		return ROW_W'(e);
	endfunction

	logic [COL_W-1:0] col_q, col_last_q;
	logic [ROW_W-1:0] row_q, rows_q;
	logic [23:0]      fore_q, back_q;
	logic [7:0]       byte_q, lead_q;
	logic             pend_q;
	logic             valid_q;
	logic [ROW_W-1:0] row_inc;
	logic [ROW_W-1:0] row_dec;
	logic             home;

	assign row_inc = ROW_W'(row_q + 1'b1);
	assign row_dec = ROW_W'(row_q - 1'b1);
	assign home    = cfg_wr && (cfg_index == REG_COLUMNS || cfg_index == REG_ROWS);

	always_comb begin
		stat.is_wide   = byte_q >= WIDE_FIRST;
		stat.is_bs     = byte_q == CH_BS;
		stat.is_nl     = byte_q == CH_NL;
		stat.is_cr     = byte_q == CH_CR;
		stat.is_tab    = byte_q == CH_TAB;
		stat.lead_pend = pend_q;
		stat.last_col  = col_q == col_last_q;
		stat.origin    = (row_q == '0) && (col_q == '0);
		stat.over      = row_q == rows_q;
		stat.adv1_over = (col_q == col_last_q) && (row_inc == rows_q);
		stat.adv2_over = (col_q == col_last_q || col_q == COL_W'(col_last_q - 1'b1))
			&& (row_inc == rows_q);
		stat.out_free  = !valid_q || out_ready;
	end

	// geometry, colors and lead byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_last_q <= clamp_cols(8'd80);
			rows_q     <= clamp_rows(7'd25);
			fore_q     <= 24'hFFFFFF;
			back_q     <= '0;
			pend_q     <= 1'b0;
			lead_q     <= '0;
		end else begin
			if (cfg_wr) begin
				unique case (cfg_index)
					REG_COLUMNS: col_last_q <= clamp_cols(cfg_data[7:0]);
					REG_ROWS:    rows_q     <= clamp_rows(cfg_data[6:0]);
					REG_FORE:    fore_q     <= cfg_data;
					REG_BACK:    back_q     <= cfg_data;
				endcase
			end
			if (cmd.set_lead) begin
				pend_q <= 1'b1;
				lead_q <= byte_q;
			end else if (cmd.clr_lead) begin
				pend_q <= 1'b0;
			end
		end
	end

	// cursor kept as row and column; row may sit at rows_q until the scroll step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (home) begin
			row_q <= '0;
			col_q <= '0;
		end else begin
			case (cmd.mv)
				MV_ADV1: begin
					if (col_q == col_last_q) begin
						col_q <= '0;
						row_q <= row_inc;
					end else begin
						col_q <= COL_W'(col_q + 1'b1);
					end
				end
				MV_ADV2: begin
					if (col_q == col_last_q) begin
						col_q <= COL_W'(1);
						row_q <= row_inc;
					end else if (col_q == COL_W'(col_last_q - 1'b1)) begin
						col_q <= '0;
						row_q <= row_inc;
					end else begin
						col_q <= COL_W'(col_q + 2'd2);
					end
				end
				MV_BACK: begin
					if (col_q == '0) begin
						col_q <= col_last_q;
						row_q <= row_dec;
					end else begin
						col_q <= COL_W'(col_q - 1'b1);
					end
				end
				MV_NL: begin
					col_q <= '0;
					row_q <= row_inc;
				end
				MV_CR:     col_q <= '0;
				MV_SCROLL: row_q <= row_dec;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load)
			byte_q <= in_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (cmd.emit)
			valid_q <= 1'b1;
		else if (out_ready)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_last <= cmd.last;
			// scroll reports the bottom row, column zero
			out_row  <= (cmd.dop == DOP_SCROLL) ? 6'(rows_q - 1'b1) : 6'(row_q);
			out_col  <= (cmd.dop == DOP_SCROLL) ? 7'd0 : 7'(col_q);
			unique case (cmd.dop)
				DOP_CHAR: begin
					out_kind  <= KIND_NARROW;
					out_code1 <= byte_q;
					out_code2 <= '0;
					out_color <= (byte_q == CH_SPACE) ? back_q : fore_q;
				end
				DOP_SPACE: begin
					out_kind  <= KIND_NARROW;
					out_code1 <= CH_SPACE;
					out_code2 <= '0;
					out_color <= back_q;
				end
				DOP_WIDE: begin
					out_kind  <= KIND_WIDE;
					out_code1 <= lead_q;
					out_code2 <= byte_q;
					out_color <= fore_q;
				end
				DOP_SCROLL: begin
					out_kind  <= KIND_SCROLL;
					out_code1 <= '0;
					out_code2 <= '0;
					out_color <= back_q;
				end
			endcase
		end
	end

	assign out_valid = valid_q;

endmodule

// ----- design/tcc_control.sv -----
// Sequencer: decodes the byte and steps through draws and scroll checks.
module tcc_control #(
	parameter int TAB_SPACES = 5
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  tcc_pkg::tcc_stat_t stat,
	output tcc_pkg::tcc_cmd_t  cmd
);
	import tcc_pkg::*;

	localparam int CNT_W = $clog2(TAB_SPACES + 1);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_DECODE = 2'd1;
	localparam logic [1:0] ST_DRAW   = 2'd2;
	localparam logic [1:0] ST_SCROLL = 2'd3;

	// draw step kinds
	localparam logic [1:0] OP_CHAR  = 2'd0;
	localparam logic [1:0] OP_PAD   = 2'd1;
	localparam logic [1:0] OP_WIDE  = 2'd2;
	localparam logic [1:0] OP_ERASE = 2'd3;

	logic [1:0]       state_q, state_d;
	logic [1:0]       op_q, op_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             more;
	logic             over_after;

	always_comb begin
		cmd        = '0;
		state_d    = state_q;
		op_d       = op_q;
		cnt_d      = cnt_q;
		more       = 1'b0;
		over_after = 1'b0;
		in_ready   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DECODE;
				end
			end
			ST_DECODE: begin
				cnt_d = '0;
				priority if (stat.is_wide) begin
					if (!stat.lead_pend) begin
						cmd.set_lead = 1'b1;
						// lead byte in the last column: pad with one space first
						if (stat.last_col) begin
							op_d    = OP_PAD;
							cnt_d   = CNT_W'(1);
							state_d = ST_DRAW;
						end else begin
							state_d = ST_IDLE;
						end
					end else begin
						cmd.clr_lead = 1'b1;
						op_d         = OP_WIDE;
						state_d      = ST_DRAW;
					end
				end else if (stat.is_bs) begin
					if (stat.origin) begin
						state_d = ST_IDLE;
					end else begin
						cmd.mv  = MV_BACK;
						op_d    = OP_ERASE;
						state_d = ST_DRAW;
					end
				end else if (stat.is_nl) begin
					cmd.mv  = MV_NL;
					state_d = ST_SCROLL;
				end else if (stat.is_cr) begin
					cmd.mv  = MV_CR;
					state_d = ST_IDLE;
				end else if (stat.is_tab) begin
					op_d    = OP_PAD;
					cnt_d   = CNT_W'(TAB_SPACES);
					state_d = ST_DRAW;
				end else begin
					op_d    = OP_CHAR;
					state_d = ST_DRAW;
				end
			end
			ST_DRAW: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					unique case (op_q)
						OP_CHAR: begin
							cmd.dop    = DOP_CHAR;
							cmd.mv     = MV_ADV1;
							over_after = stat.adv1_over;
						end
						OP_PAD: begin
							cmd.dop    = DOP_SPACE;
							cmd.mv     = MV_ADV1;
							over_after = stat.adv1_over;
							more       = cnt_q > CNT_W'(1);
							cnt_d      = CNT_W'(cnt_q - 1'b1);
						end
						OP_WIDE: begin
							cmd.dop    = DOP_WIDE;
							cmd.mv     = MV_ADV2;
							over_after = stat.adv2_over;
						end
						OP_ERASE: begin
							cmd.dop = DOP_SPACE;
							cmd.mv  = MV_NONE;
						end
					endcase
					cmd.last = !more && !over_after;
					priority if (over_after)
						state_d = ST_SCROLL;
					else if (more)
						state_d = ST_DRAW;
					else
						state_d = ST_IDLE;
				end
			end
			ST_SCROLL: begin
				more = cnt_q != '0;
				if (!stat.over) begin
					state_d = more ? ST_DRAW : ST_IDLE;
				end else if (stat.out_free) begin
					cmd.emit = 1'b1;
					cmd.dop  = DOP_SCROLL;
					cmd.mv   = MV_SCROLL;
					cmd.last = !more;
					state_d  = more ? ST_DRAW : ST_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_CHAR;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

// ----- design/text_console_cursor_controller.sv -----
// A byte accepted in the idle state is registered and decoded in the decode state; its first
// result, if any, is loaded from the draw or scroll state. A new byte is taken only in the idle
// state, once all results of the last byte are loaded; at most one result per cycle.
// A stalled result register holds the sequencer in place.
// Reset (arst_n low, asynchronous): cursor home, no lead byte, 80 columns, 25 rows,
// white foreground, black background, no result pending.
`include "text_console_cursor_controller_macros.svh"

module text_console_cursor_controller #(
	parameter int MAX_COLS   = 128,
	parameter int MAX_ROWS   = 64,
	parameter int TAB_SPACES = 5
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // [5:0] cell_row, [12:6] cell_col, [20:13] code_first,
	                               // [28:21] code_second, [52:29] draw_color, rest zero
	output logic [1:0]  m_tuser,   // [1:0] kind
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data
);
	import tcc_pkg::*;

	tcc_cmd_t   cmd;
	tcc_stat_t  stat;
	logic [5:0] row;
	logic [6:0] col;
	logic [7:0] code1, code2;
	logic [23:0] color;

	assign cfg_ready = 1'b1;

	tcc_control #(
		.TAB_SPACES(TAB_SPACES)
	) u_control (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	tcc_datapath #(
		.MAX_COLS(MAX_COLS),
		.MAX_ROWS(MAX_ROWS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_byte   (s_tdata),
		.cmd       (cmd),
		.cfg_wr    (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_ready (m_tready),
		.stat      (stat),
		.out_valid (m_tvalid),
		.out_kind  (m_tuser),
		.out_row   (row),
		.out_col   (col),
		.out_code1 (code1),
		.out_code2 (code2),
		.out_color (color),
		.out_last  (m_tlast)
	);

	assign m_tdata = {3'b000, color, code2, code1, col, row};

	`TCC_ASSERT_NEXT(a_busy_after_request, s_tvalid && s_tready, !s_tready, "input taken while busy")
	`TCC_ASSERT_NOW(a_no_overwrite, cmd.emit, !m_tvalid || m_tready, "result overwritten")
	`TCC_ASSERT_NEXT(a_emit_shows, cmd.emit, m_tvalid, "loaded result not presented")
	`TCC_ASSERT_NOW(a_idle_no_emit, s_tready, !cmd.emit, "result emitted while idle")

endmodule
